### rtl/formula_tokenizer_macros.svh
// assertion macros used by the formula tokenizer checker
`ifndef FORMULA_TOKENIZER_MACROS_SVH
`define FORMULA_TOKENIZER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FTOK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("formula_tokenizer: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define FTOK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("formula_tokenizer: next-cycle check failed");

`endif

### rtl/ftok_pkg.sv
// shared types, constants and character classes of the formula tokenizer
package ftok_pkg;

    localparam int MAX_FORMULA_LEN = 256;
    localparam int MAX_TOKEN_LEN   = 49;

    localparam int CHAR_W  = 8;
    localparam int POS_W   = $clog2(MAX_FORMULA_LEN + 1);
    localparam int START_W = 8;
    localparam int LEN_W   = 6;
    localparam int KIND_W  = 5;
    localparam int ERR_W   = 2;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        M_IDLE, M_ALPHA, M_CELL, M_INT, M_FRAC, M_LT, M_GT, M_DEAD
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        K_EQ     = 5'd0,
        K_CELL   = 5'd1,
        K_NUM    = 5'd2,
        K_PLUS   = 5'd3,
        K_MINUS  = 5'd4,
        K_MUL    = 5'd5,
        K_DIV    = 5'd6,
        K_FUNC   = 5'd7,
        K_LPAREN = 5'd8,
        K_RPAREN = 5'd9,
        K_COLON  = 5'd10,
        K_LT     = 5'd11,
        K_GT     = 5'd12,
        K_LE     = 5'd13,
        K_GE     = 5'd14,
        K_NE     = 5'd15,
        K_COMMA  = 5'd16,
        K_EOF    = 5'd17,
        K_ERR    = 5'd18
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        E_NONE, E_IDENT, E_CHAR, E_LONG
    } t_err;

    typedef struct packed {
        t_kind               kind;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    length;
        t_err                err;
        logic                last;
        logic                done;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c inside {CH_SPACE, [CH_TAB:CH_CR]});
    endfunction

    function automatic logic is_single(input logic [CHAR_W-1:0] c);
        return (c inside {CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                          CH_LPAREN, CH_RPAREN, CH_COLON, CH_COMMA});
    endfunction

    function automatic t_kind single_kind(input logic [CHAR_W-1:0] c);
        t_kind k;
        case (c)
            CH_EQ:     k = K_EQ;
            CH_PLUS:   k = K_PLUS;
            CH_MINUS:  k = K_MINUS;
            CH_STAR:   k = K_MUL;
            CH_SLASH:  k = K_DIV;
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_COLON:  k = K_COLON;
            CH_COMMA:  k = K_COMMA;
            default:   k = K_ERR;
        endcase
        return k;
    endfunction

    function automatic t_result make_result(input t_kind kind,
                                            input logic [START_W-1:0] start,
                                            input logic [LEN_W-1:0] length,
                                            input t_err err,
                                            input logic done);
        t_result r;
        r.kind   = kind;
        r.start  = start;
        r.length = length;
        r.err    = err;
        r.last   = 1'b0;
        r.done   = done;
        return r;
    endfunction

endpackage

### rtl/ftok_lexer.sv
// scanner state and per-item token decision, up to two results per item
module ftok_lexer
    import ftok_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [CHAR_W-1:0] i_ch,
    input  logic              i_eof,
    output t_push             o_push
);

    typedef struct packed {
        logic  term;
        logic  eof_emit;
        logic  long_err;
        logic  ident_err;
        logic  flush;
        t_kind flush_kind;
        logic  flush_len2;
        logic  extend;
        t_mode ext_mode;
        logic  idle;
    } t_step;

    t_mode               r_mode,   n_mode;
    logic [POS_W-1:0]    r_pos,    n_pos;
    logic [START_W-1:0]  r_pstart, n_pstart;
    logic [LEN_W-1:0]    r_plen,   n_plen;

    t_step              s;
    logic               ext_over;
    logic               c_letter, c_digit, c_space, c_single;
    logic               c_unknown;
    logic [START_W-1:0] p_start;
    t_result            res_a, res_b;
    logic               a_v, b_v;

    assign c_letter  = is_letter(i_ch);
    assign c_digit   = is_digit(i_ch);
    assign c_space   = is_space(i_ch);
    assign c_single  = is_single(i_ch);
    assign c_unknown = !c_letter && !c_digit && !c_space && !c_single
                       && (i_ch != CH_LT) && (i_ch != CH_GT);
    assign p_start   = START_W'(r_pos);
    assign ext_over  = s.extend && (r_plen >= LEN_W'(MAX_TOKEN_LEN));

    // decode of the item against the current mode
    always_comb begin
        s            = '0;
        s.flush_kind = K_CELL;
        s.ext_mode   = r_mode;
        if (i_eof) begin
            s.term     = 1'b1;
            s.eof_emit = (r_mode != M_DEAD) && (r_mode != M_ALPHA);
            case (r_mode)
                M_ALPHA: s.ident_err = 1'b1;
                M_CELL: begin
                    s.flush      = 1'b1;
                    s.flush_kind = K_CELL;
                end
                M_INT, M_FRAC: begin
                    s.flush      = 1'b1;
                    s.flush_kind = K_NUM;
                end
                M_LT: begin
                    s.flush      = 1'b1;
                    s.flush_kind = K_LT;
                end
                M_GT: begin
                    s.flush      = 1'b1;
                    s.flush_kind = K_GT;
                end
                default: ;
            endcase
        end else if (r_mode != M_DEAD) begin
            if (r_pos >= POS_W'(MAX_FORMULA_LEN)) begin
                s.long_err = 1'b1;
            end else begin
                case (r_mode)
                    M_ALPHA: begin
                        if (c_letter) begin
                            s.extend = 1'b1;
                        end else if (c_digit) begin
                            s.extend   = 1'b1;
                            s.ext_mode = M_CELL;
                        end else if (i_ch == CH_LPAREN) begin
                            s.flush      = 1'b1;
                            s.flush_kind = K_FUNC;
                            s.idle       = 1'b1;
                        end else begin
                            s.ident_err = 1'b1;
                        end
                    end
                    M_CELL: begin
                        if (c_digit) begin
                            s.extend = 1'b1;
                        end else begin
                            s.flush      = 1'b1;
                            s.flush_kind = K_CELL;
                            s.idle       = 1'b1;
                        end
                    end
                    M_INT: begin
                        if (c_digit) begin
                            s.extend = 1'b1;
                        end else if (i_ch == CH_DOT) begin
                            s.extend   = 1'b1;
                            s.ext_mode = M_FRAC;
                        end else begin
                            s.flush      = 1'b1;
                            s.flush_kind = K_NUM;
                            s.idle       = 1'b1;
                        end
                    end
                    M_FRAC: begin
                        if (c_digit) begin
                            s.extend = 1'b1;
                        end else begin
                            s.flush      = 1'b1;
                            s.flush_kind = K_NUM;
                            s.idle       = 1'b1;
                        end
                    end
                    M_LT: begin
                        s.flush = 1'b1;
                        if (i_ch == CH_EQ) begin
                            s.flush_kind = K_LE;
                            s.flush_len2 = 1'b1;
                        end else if (i_ch == CH_GT) begin
                            s.flush_kind = K_NE;
                            s.flush_len2 = 1'b1;
                        end else begin
                            s.flush_kind = K_LT;
                            s.idle       = 1'b1;
                        end
                    end
                    M_GT: begin
                        s.flush = 1'b1;
                        if (i_ch == CH_EQ) begin
                            s.flush_kind = K_GE;
                            s.flush_len2 = 1'b1;
                        end else begin
                            s.flush_kind = K_GT;
                            s.idle       = 1'b1;
                        end
                    end
                    default: s.idle = 1'b1;
                endcase
            end
        end
    end

    // next state
    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        if (i_fire) begin
            if (s.term) begin
                n_mode   = M_IDLE;
                n_pos    = '0;
                n_pstart = '0;
                n_plen   = '0;
            end else if (s.long_err) begin
                n_mode = M_DEAD;
                n_plen = '0;
            end else if (r_mode != M_DEAD) begin
                n_pos = r_pos + 1'b1;
                if (s.ident_err || ext_over) begin
                    n_mode = M_DEAD;
                    n_plen = '0;
                end else if (s.extend) begin
                    n_mode = s.ext_mode;
                    n_plen = r_plen + 1'b1;
                end
                if (s.flush) begin
                    n_mode = M_IDLE;
                    n_plen = '0;
                end
                if (s.idle) begin
                    n_mode = M_IDLE;
                    if (!c_space && !c_single) begin
                        n_pstart = p_start;
                        n_plen   = LEN_W'(1);
                        if (c_letter) begin
                            n_mode = M_ALPHA;
                        end else if (c_digit) begin
                            n_mode = M_INT;
                        end else if (i_ch == CH_LT) begin
                            n_mode = M_LT;
                        end else if (i_ch == CH_GT) begin
                            n_mode = M_GT;
                        end else begin
                            n_mode = M_DEAD;
                            n_plen = '0;
                        end
                    end
                end
            end
        end
    end

    // results: flushed token first, then the item's own result
    always_comb begin
        a_v   = 1'b0;
        b_v   = 1'b0;
        res_a = '0;
        res_b = '0;
        if (i_fire) begin
            if (s.flush) begin
                a_v   = 1'b1;
                res_a = make_result(s.flush_kind, r_pstart,
                                    s.flush_len2 ? LEN_W'(2) : r_plen, E_NONE, 1'b0);
            end
            b_v = 1'b1;
            if (s.ident_err) begin
                res_b = make_result(K_ERR, r_pstart, '0, E_IDENT, 1'b1);
            end else if (s.term && s.eof_emit) begin
                res_b = make_result(K_EOF, p_start, '0, E_NONE, 1'b1);
            end else if (s.long_err) begin
                res_b = make_result(K_ERR, p_start, '0, E_LONG, 1'b1);
            end else if (ext_over) begin
                res_b = make_result(K_ERR, r_pstart, '0, E_LONG, 1'b1);
            end else if (s.idle && c_single) begin
                res_b = make_result(single_kind(i_ch), p_start, LEN_W'(1), E_NONE, 1'b0);
            end else if (s.idle && c_unknown) begin
                res_b = make_result(K_ERR, p_start, '0, E_CHAR, 1'b1);
            end else begin
                b_v = 1'b0;
            end
        end
        o_push.num = {1'b0, a_v} + {1'b0, b_v};
        if (a_v) begin
            o_push.res0      = res_a;
            o_push.res1      = res_b;
            o_push.res0.last = !b_v;
            o_push.res1.last = 1'b1;
        end else begin
            o_push.res0      = res_b;
            o_push.res1      = res_b;
            o_push.res0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_pstart <= '0;
            r_plen   <= '0;
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
        end
    end

endmodule

### rtl/ftok_result_queue.sv
// small result queue taking up to two results per cycle, one out per cycle
module ftok_result_queue
    import ftok_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head
);

    t_result             r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_wr, n_wr;
    logic [RQ_PTR_W-1:0] r_rd, n_rd;
    logic [RQ_CNT_W-1:0] r_cnt, n_cnt;
    logic [RQ_PTR_W-1:0] wr_next;

    assign wr_next = r_wr + 1'b1;
    assign o_room  = r_cnt <= RQ_CNT_W'(RQ_DEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr + RQ_PTR_W'(i_push.num);
        n_rd  = i_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + RQ_CNT_W'(i_push.num) - RQ_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

endmodule

### rtl/formula_tokenizer.sv
// formula tokenizer top level: input register, lexer and result queue
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_ch, i_end_of_formula
//   result   out        o_valid / i_stall    o_token_kind .. o_formula_done
//
// an item is taken each cycle while o_stall is low; its results are registered
// in the result queue; input stalls while three or more results wait in the
// four-entry queue, so that a two-result item always finds room
// synchronous active-low reset returns the lexer to idle at position zero
// and empties the result queue
module formula_tokenizer
    import ftok_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [CHAR_W-1:0]   i_ch,
    input  logic                i_end_of_formula,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [KIND_W-1:0]   o_token_kind,
    output logic [START_W-1:0]  o_token_start,
    output logic [LEN_W-1:0]    o_token_length,
    output logic [ERR_W-1:0]    o_error_code,
    output logic                o_last_of_item,
    output logic                o_formula_done
);

    logic              r_in_valid, n_in_valid;
    logic [CHAR_W-1:0] r_ch;
    logic              r_eof;
    logic              load;
    logic              fire;
    logic              room;
    logic              pop;
    t_push             push;
    t_result           head;

    assign fire    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign load    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (load) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ch  <= i_ch;
            r_eof <= i_end_of_formula;
        end
    end

    ftok_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_ch    (r_ch),
        .i_eof   (r_eof),
        .o_push  (push)
    );

    ftok_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_room  (room),
        .o_valid (o_valid),
        .o_head  (head)
    );

    assign o_token_kind   = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.length;
    assign o_error_code   = head.err;
    assign o_last_of_item = head.last;
    assign o_formula_done = head.done;

endmodule

### rtl/ftok_checker.sv
// port-level checks on the formula tokenizer results, bound to the top level
`include "formula_tokenizer_macros.svh"

module ftok_checker
    import ftok_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic [KIND_W-1:0]   o_token_kind,
    input logic [START_W-1:0]  o_token_start,
    input logic [LEN_W-1:0]    o_token_length,
    input logic [ERR_W-1:0]    o_error_code,
    input logic                o_last_of_item,
    input logic                o_formula_done
);

    logic is_end_kind;

    assign is_end_kind = (o_token_kind == K_EOF) || (o_token_kind == K_ERR);

    `FTOK_ASSERT_NOW(a_done_is_last, o_valid && o_formula_done, o_last_of_item)
    `FTOK_ASSERT_NOW(a_done_kind, o_valid && o_formula_done, is_end_kind)
    `FTOK_ASSERT_NOW(a_err_code, o_valid, (o_token_kind == K_ERR) == (o_error_code != E_NONE))
    `FTOK_ASSERT_NOW(a_end_len, o_valid && is_end_kind, o_token_length == '0)
    `FTOK_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_token_kind) && $stable(o_token_start))

endmodule

bind formula_tokenizer ftok_checker u_ftok_checker (.*);

### verif/testbench.sv
// self-checking testbench for the formula tokenizer: streamed formulas against a token predictor
module testbench
    import ftok_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [CHAR_W-1:0]  i_ch;
    logic               i_end_of_formula;
    logic               o_valid;
    logic               i_stall;
    logic [KIND_W-1:0]  o_token_kind;
    logic [START_W-1:0] o_token_start;
    logic [LEN_W-1:0]   o_token_length;
    logic [ERR_W-1:0]   o_error_code;
    logic               o_last_of_item;
    logic               o_formula_done;

    t_result     expected_tokens[$];
    t_result     item_tokens[$];
    t_mode       scan_state;
    int unsigned char_count;
    int unsigned tok_start;
    int unsigned tok_len;
    int unsigned live_items;
    int unsigned mismatch_count;
    bit          src_gaps_on;
    bit          sink_stalls_on;
    bit          hold_request;

    formula_tokenizer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_ch             (i_ch),
        .i_end_of_formula (i_end_of_formula),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_token_kind     (o_token_kind),
        .o_token_start    (o_token_start),
        .o_token_length   (o_token_length),
        .o_error_code     (o_error_code),
        .o_last_of_item   (o_last_of_item),
        .o_formula_done   (o_formula_done)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit letter_char(logic [CHAR_W-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit digit_char(logic [CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit blank_char(logic [CHAR_W-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit operator_char(logic [CHAR_W-1:0] c, output t_kind k);
        k = K_ERR;
        case (c)
            CH_EQ:     k = K_EQ;
            CH_PLUS:   k = K_PLUS;
            CH_MINUS:  k = K_MINUS;
            CH_STAR:   k = K_MUL;
            CH_SLASH:  k = K_DIV;
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_COLON:  k = K_COLON;
            CH_COMMA:  k = K_COMMA;
            default:   k = K_ERR;
        endcase
        return k != K_ERR;
    endfunction

    function automatic void post_token(t_kind k, int unsigned s, int unsigned n, t_err e,
                                       bit done);
        t_result r;
        r.kind   = k;
        r.start  = START_W'(s);
        r.length = LEN_W'(n);
        r.err    = e;
        r.last   = 1'b0;
        r.done   = done;
        item_tokens.push_back(r);
    endfunction

    function automatic void abort_formula(int unsigned s, t_err e);
        post_token(K_ERR, s, 0, e, 1'b1);
        scan_state = M_DEAD;
        tok_len = 0;
    endfunction

    function automatic void close_token(t_kind k);
        post_token(k, tok_start, tok_len, E_NONE, 1'b0);
        tok_len = 0;
        scan_state = M_IDLE;
    endfunction

    function automatic void grow_token();
        if (tok_len >= MAX_TOKEN_LEN) begin
            abort_formula(tok_start, E_LONG);
        end else begin
            tok_len++;
        end
    endfunction

    function automatic void open_token(logic [CHAR_W-1:0] c, int unsigned p);
        t_kind k;
        scan_state = M_IDLE;
        if (blank_char(c)) begin
            return;
        end
        if (operator_char(c, k)) begin
            post_token(k, p, 1, E_NONE, 1'b0);
            return;
        end
        tok_start = p;
        tok_len = 1;
        if (letter_char(c)) begin
            scan_state = M_ALPHA;
        end else if (digit_char(c)) begin
            scan_state = M_INT;
        end else if (c == CH_LT) begin
            scan_state = M_LT;
        end else if (c == CH_GT) begin
            scan_state = M_GT;
        end else begin
            abort_formula(p, E_CHAR);
        end
    endfunction

    function automatic void tokenize_item(logic [CHAR_W-1:0] c, logic eof);
        int unsigned p;
        item_tokens.delete();
        if (eof) begin
            if (scan_state != M_DEAD) begin
                live_items++;
            end
            case (scan_state)
                M_ALPHA:       abort_formula(tok_start, E_IDENT);
                M_CELL:        close_token(K_CELL);
                M_INT, M_FRAC: close_token(K_NUM);
                M_LT:          close_token(K_LT);
                M_GT:          close_token(K_GT);
                default:       ;
            endcase
            if (scan_state != M_DEAD) begin
                post_token(K_EOF, char_count, 0, E_NONE, 1'b1);
            end
            scan_state = M_IDLE;
            char_count = 0;
            tok_start = 0;
            tok_len = 0;
        end else if (scan_state != M_DEAD) begin
            live_items++;
            p = char_count;
            if (p >= MAX_FORMULA_LEN) begin
                abort_formula(p, E_LONG);
            end else begin
                char_count = p + 1;
                case (scan_state)
                    M_ALPHA: begin
                        if (letter_char(c)) begin
                            grow_token();
                        end else if (digit_char(c)) begin
                            scan_state = M_CELL;
                            grow_token();
                        end else if (c == CH_LPAREN) begin
                            close_token(K_FUNC);
                            open_token(c, p);
                        end else begin
                            abort_formula(tok_start, E_IDENT);
                        end
                    end
                    M_CELL: begin
                        if (digit_char(c)) begin
                            grow_token();
                        end else begin
                            close_token(K_CELL);
                            open_token(c, p);
                        end
                    end
                    M_INT: begin
                        if (digit_char(c)) begin
                            grow_token();
                        end else if (c == CH_DOT) begin
                            scan_state = M_FRAC;
                            grow_token();
                        end else begin
                            close_token(K_NUM);
                            open_token(c, p);
                        end
                    end
                    M_FRAC: begin
                        if (digit_char(c)) begin
                            grow_token();
                        end else begin
                            close_token(K_NUM);
                            open_token(c, p);
                        end
                    end
                    M_LT: begin
                        if (c == CH_EQ) begin
                            tok_len = 2;
                            close_token(K_LE);
                        end else if (c == CH_GT) begin
                            tok_len = 2;
                            close_token(K_NE);
                        end else begin
                            close_token(K_LT);
                            open_token(c, p);
                        end
                    end
                    M_GT: begin
                        if (c == CH_EQ) begin
                            tok_len = 2;
                            close_token(K_GE);
                        end else begin
                            close_token(K_GT);
                            open_token(c, p);
                        end
                    end
                    default: open_token(c, p);
                endcase
            end
        end
        if (item_tokens.size() > 0) begin
            item_tokens[item_tokens.size() - 1].last = 1'b1;
        end
        foreach (item_tokens[i]) begin
            expected_tokens.push_back(item_tokens[i]);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tokens.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: token expected none actual kind %0d start %0d",
                         $time, o_token_kind, o_token_start);
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", want.kind, o_token_kind);
                check_field("token_start", want.start, o_token_start);
                check_field("token_length", want.length, o_token_length);
                check_field("error_code", want.err, o_error_code);
                check_field("last_of_item", want.last, o_last_of_item);
                check_field("formula_done", want.done, o_formula_done);
            end
        end
    end

    // result side stall pattern and long hold-off
    initial begin : result_sink
        int unsigned run;
        int unsigned held;
        bit level;
        i_stall = 1'b0;
        run = 0;
        level = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                for (held = 0; held < 120; held++) begin
                    @(negedge i_clk);
                end
                i_stall <= 1'b0;
                run = 0;
                level = 1'b0;
            end else begin
                if (run == 0) begin
                    level = sink_stalls_on && !level;
                    run = pick_gap() + 1;
                end
                i_stall <= level;
                run--;
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_item(logic [CHAR_W-1:0] c, logic eof);
        int unsigned gap;
        gap = src_gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch <= c;
        i_end_of_formula <= eof;
        do @(posedge i_clk); while (o_stall);
        tokenize_item(c, eof);
    endtask

    task automatic send_end();
        send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_formula(string text);
        for (int i = 0; i < text.len(); i++) begin
            send_item(text[i], 1'b0);
        end
    endtask

    task automatic send_repeat(logic [CHAR_W-1:0] c, int unsigned count);
        repeat (count) send_item(c, 1'b0);
    endtask

    task automatic send_letters(int unsigned count);
        repeat (count) begin
            if ($urandom_range(0, 1)) begin
                send_item(CHAR_W'($urandom_range(65, 90)), 1'b0);
            end else begin
                send_item(CHAR_W'($urandom_range(97, 122)), 1'b0);
            end
        end
    endtask

    task automatic send_digits(int unsigned count);
        repeat (count) send_item(CHAR_W'($urandom_range(48, 57)), 1'b0);
    endtask

    task automatic send_blank();
        int unsigned code;
        code = $urandom_range(8, 13);
        send_item(code == 8 ? CH_SPACE : CHAR_W'(code), 1'b0);
    endtask

    task automatic send_operator();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 8))
            0:       c = CH_EQ;
            1:       c = CH_PLUS;
            2:       c = CH_MINUS;
            3:       c = CH_STAR;
            4:       c = CH_SLASH;
            5:       c = CH_LPAREN;
            6:       c = CH_RPAREN;
            7:       c = CH_COLON;
            default: c = CH_COMMA;
        endcase
        send_item(c, 1'b0);
    endtask

    task automatic send_random_token();
        int unsigned count;
        case ($urandom_range(0, 7))
            0, 1: begin
                send_letters($urandom_range(1, 3));
                // occasionally a bare identifier
                if ($urandom_range(0, 15) != 0) begin
                    send_digits($urandom_range(1, 4));
                end
            end
            2: begin
                send_letters($urandom_range(1, 5));
                send_item(CH_LPAREN, 1'b0);
            end
            3, 4: begin
                count = ($urandom_range(0, 19) == 0) ? $urandom_range(45, 52)
                                                     : $urandom_range(1, 5);
                send_digits(count);
                if ($urandom_range(0, 1)) begin
                    send_item(CH_DOT, 1'b0);
                    send_digits($urandom_range(0, 3));
                end
            end
            5: send_operator();
            6: begin
                send_item($urandom_range(0, 1) ? CH_LT : CH_GT, 1'b0);
                case ($urandom_range(0, 2))
                    0:       send_item(CH_EQ, 1'b0);
                    1:       send_item(CH_GT, 1'b0);
                    default: ;
                endcase
            end
            default: send_item(CH_RPAREN, 1'b0);
        endcase
    endtask

    task automatic test_operators();
        send_formula("=SUM(A1:B22)");
        send_end();
        send_formula("1.5+2-3*4/5,6");
        send_end();
        send_formula("1<2<=3>=4<>5>6<<");
        send_end();
        send_formula("ab(c12)A1<>B2>");
        send_end();
    endtask

    task automatic test_flush_at_end();
        send_formula("A1");
        send_end();
        send_formula("7.");
        send_end();
        send_formula(">");
        send_end();
        send_end();
    endtask

    task automatic test_whitespace();
        for (int code = CH_TAB; code <= CH_CR; code++) begin
            send_item(CHAR_W'(code), 1'b0);
        end
        send_item(CH_SPACE, 1'b0);
        send_formula("1 x2\t<\r=");
        send_end();
    endtask

    task automatic test_errors();
        send_formula("abc+1");
        send_end();
        send_formula("xy");
        send_end();
        send_formula("1#2");
        send_end();
        send_formula("1.2.3");
        send_end();
        send_formula("A1(");
        send_end();
        send_item(8'h80, 1'b0);
        send_end();
        send_item(8'hFF, 1'b0);
        send_end();
        send_item(8'h00, 1'b0);
        send_formula("12");
        send_end();
    endtask

    task automatic test_token_limit();
        send_repeat("7", MAX_TOKEN_LEN);
        send_item(CH_PLUS, 1'b0);
        send_end();
        send_item(CH_SPACE, 1'b0);
        send_repeat("3", MAX_TOKEN_LEN + 2);
        send_end();
        send_item(CH_EQ, 1'b0);
        send_repeat("Q", MAX_TOKEN_LEN + 1);
        send_end();
        send_item("A", 1'b0);
        send_repeat("0", MAX_TOKEN_LEN);
        send_end();
    endtask

    task automatic test_formula_limit();
        repeat (MAX_FORMULA_LEN / 2) send_formula("1+");
        send_end();
        // a number that is still open when the formula overflows
        send_repeat(CH_MINUS, MAX_FORMULA_LEN - 1);
        send_formula("9876");
        send_end();
    endtask

    task automatic test_backpressure();
        src_gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (20) send_formula("A1+");
        send_end();
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_formulas();
        int unsigned target;
        int unsigned count;
        bit noisy;
        target = live_items + 100;
        while (live_items < target) begin
            src_gaps_on = $urandom_range(0, 3) != 0;
            sink_stalls_on = $urandom_range(0, 3) != 0;
            noisy = $urandom_range(0, 4) == 0;
            count = $urandom_range(1, 12);
            repeat (count) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_blank();
                end
                send_random_token();
                if (noisy && $urandom_range(0, 3) == 0) begin
                    send_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
                end
            end
            send_end();
        end
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial begin : stimulus
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ch = '0;
        i_end_of_formula = 1'b0;
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        hold_request = 1'b0;
        scan_state = M_IDLE;
        char_count = 0;
        tok_start = 0;
        tok_len = 0;
        live_items = 0;
        mismatch_count = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_operators();
        test_flush_at_end();
        test_whitespace();
        test_errors();
        test_token_limit();
        test_formula_limit();
        test_backpressure();
        test_random_formulas();

        @(negedge i_clk);
        i_valid <= 1'b0;
        sink_stalls_on = 1'b0;
        while (expected_tokens.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/ftok_pkg.sv
rtl/ftok_lexer.sv
rtl/ftok_result_queue.sv
rtl/formula_tokenizer.sv
rtl/ftok_checker.sv
verif/testbench.sv
